>>> rtl/core/bat_pkg.sv
package bat_pkg;

   // field widths
   localparam int SEQ_W  = 12;
   localparam int OP_W   = 2;
   localparam int SIZE_W = 11;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // word index of each register (byte address bit 2)
   localparam logic REG_START_SEQUENCE = 1'b0;
   localparam logic REG_WINDOW_SIZE    = 1'b1;

   localparam logic [SEQ_W-1:0]  START_SEQUENCE_RESET = 12'd0;
   localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET    = 11'd64;

   // event codes
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_INIT     = 2'd0;
   localparam op_type OP_TX       = 2'd1;
   localparam op_type OP_ACK      = 2'd2;
   localparam op_type OP_DISCARD  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the input beat
      logic decode;      // latch distance and result flags
      logic init;        // reload window from registers, start full clear
      logic slide;       // move start, arm clear sweep of vacated entries
      logic set_ack;     // set the acked bit of the current sequence number
      logic guard_clr;   // restart the head walk guard
      logic clear_step;  // clear one entry at the head pointer
      logic walk_read;   // read the head entry
      logic pop;         // head is acked: clear it and advance
      logic emit;        // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   ready;       // window initialized
      logic   old;         // distance of 2048 or more
      logic   beyond;      // distance at or past the window end
      logic   clr_last;    // last entry of the clear sweep
      logic   head_acked;  // head entry read back as acked
      logic   guard_ok;    // head walk may go on
      logic   out_free;    // result register can take a beat
   } status_type;

endpackage

>>> rtl/core/bat_beat_if.sv
interface bat_req_if;
   logic                        valid;
   logic                        ready;
   logic [bat_pkg::OP_W-1:0]    operation;
   logic [bat_pkg::SEQ_W-1:0]   seq_num;

   modport source (output valid, output operation, output seq_num, input ready);
   modport sink   (input valid, input operation, input seq_num, output ready);
endinterface

interface bat_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bat_pkg::SEQ_W-1:0]   starting_sequence;
   logic                        ignored_old;
   logic                        not_initialized;

   modport source (output valid, output starting_sequence, output ignored_old,
                   output not_initialized, input ready);
   modport sink   (input valid, input starting_sequence, input ignored_old,
                   input not_initialized, output ready);
endinterface

>>> rtl/core/bat_ram.sv
module bat_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/bat_csr.sv
module bat_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bat_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bat_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bat_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [bat_pkg::SEQ_W-1:0]        start_sequence,
   output logic [bat_pkg::SIZE_W-1:0]       window_size
);

   logic [bat_pkg::SEQ_W-1:0]  start_sequence_ff, start_sequence_in;
   logic [bat_pkg::SIZE_W-1:0] window_size_ff, window_size_in;
   logic                       wr_en;
   logic                       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[2];

   always_comb begin
      start_sequence_in = start_sequence_ff;
      window_size_in    = window_size_ff;
      if (wr_en) begin
         case (reg_idx)
            bat_pkg::REG_START_SEQUENCE: start_sequence_in = pwdata[bat_pkg::SEQ_W-1:0];
            bat_pkg::REG_WINDOW_SIZE:    window_size_in    = pwdata[bat_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         bat_pkg::REG_START_SEQUENCE: prdata = bat_pkg::CSR_DATA_W'(start_sequence_ff);
         bat_pkg::REG_WINDOW_SIZE:    prdata = bat_pkg::CSR_DATA_W'(window_size_ff);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_sequence_ff <= bat_pkg::START_SEQUENCE_RESET;
         window_size_ff    <= bat_pkg::WINDOW_SIZE_RESET;
      end else begin
         start_sequence_ff <= start_sequence_in;
         window_size_ff    <= window_size_in;
      end
   end

   assign start_sequence = start_sequence_ff;
   assign window_size    = window_size_ff;

endmodule

>>> rtl/core/bat_ctrl.sv
module bat_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bat_pkg::status_type   status,
   output bat_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_CLEAR  = 3'd3;
   localparam logic [2:0] ST_WREAD  = 3'd4;
   localparam logic [2:0] ST_WCHECK = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (status.op == bat_pkg::OP_INIT) begin
               cmd.init = 1'b1;
               state_in = ST_CLEAR;
            end else if (!status.ready || status.old) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.guard_clr = 1'b1;
            case (status.op)
               bat_pkg::OP_TX: begin
                  if (status.beyond) begin
                     cmd.slide = 1'b1;
                     state_in  = ST_CLEAR;
                  end else begin
                     state_in  = ST_DONE;
                  end
               end
               bat_pkg::OP_ACK: begin
                  cmd.set_ack = !status.beyond;
                  state_in    = ST_WREAD;
               end
               bat_pkg::OP_DISCARD: begin
                  cmd.slide = 1'b1;
                  state_in  = ST_CLEAR;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clr_last) begin
               state_in = (status.op == bat_pkg::OP_INIT) ? ST_DONE : ST_WREAD;
            end
         end
         ST_WREAD: begin
            cmd.walk_read = 1'b1;
            state_in      = ST_WCHECK;
         end
         ST_WCHECK: begin
            if (status.head_acked && status.guard_ok) begin
               cmd.pop  = 1'b1;
               state_in = ST_WREAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/bat_dp.sv
module bat_dp #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bat_pkg::cmd_type              cmd,
   output bat_pkg::status_type           status,
   input  logic [bat_pkg::OP_W-1:0]      req_operation,
   input  logic [bat_pkg::SEQ_W-1:0]     req_seq_num,
   input  logic [bat_pkg::SEQ_W-1:0]     cfg_start_sequence,
   input  logic [bat_pkg::SIZE_W-1:0]    cfg_window_size,
   bat_rsp_if.source                     rsp
);

   localparam int SEQ_W  = bat_pkg::SEQ_W;
   localparam int SIZE_W = bat_pkg::SIZE_W;
   localparam int IDX_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W  = IDX_W + 1;
   localparam logic [SUM_W-1:0]  DEPTH_SUM  = SUM_W'(WINDOW_MAX);
   localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(WINDOW_MAX);
   localparam logic [SIZE_W-1:0] DEPTH_SIZE = SIZE_W'(WINDOW_MAX);

   // window state
   logic [SEQ_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic             ready_ff, ready_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0] guard_ff, guard_in;

   // current event
   logic [1:0]       op_ff, op_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [SEQ_W-1:0] dist_ff, dist_in;
   logic             ign_ff, ign_in;
   logic             notinit_ff, notinit_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SEQ_W-1:0] rsp_seq_ff, rsp_seq_in;
   logic             rsp_ign_ff, rsp_ign_in;
   logic             rsp_notinit_ff, rsp_notinit_in;

   logic [SEQ_W-1:0] seq_dist;
   logic [SEQ_W-1:0] size_seq;
   logic             beyond;
   logic [SEQ_W-1:0] slide_count;
   logic [CNT_W-1:0] clr_count;
   logic [SUM_W-1:0] ptr_inc;
   logic [IDX_W-1:0] ptr_step;
   logic [SUM_W-1:0] ack_sum;
   logic [SUM_W-1:0] ack_wrap;
   logic [IDX_W-1:0] ack_addr;
   logic [CNT_W-1:0] size_clamp;
   logic             is_init;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic             ram_rdata;

   assign is_init  = (op_ff == bat_pkg::OP_INIT);
   assign seq_dist = seq_ff - start_ff;
   assign size_seq = SEQ_W'(size_ff);
   assign beyond   = (dist_ff >= size_seq);

   always_comb begin
      if (op_ff == bat_pkg::OP_TX) begin
         slide_count = dist_ff - size_seq + SEQ_W'(1);
      end else begin
         slide_count = dist_ff + SEQ_W'(1);
      end
   end

   // vacated entries beyond the active size are already clear
   assign clr_count = (slide_count >= size_seq) ? size_ff : CNT_W'(slide_count);

   assign ptr_inc  = {1'b0, ptr_ff} + SUM_W'(1);
   assign ptr_step = (ptr_inc == DEPTH_SUM) ? '0 : ptr_inc[IDX_W-1:0];

   // ack lands below the active size, so one wrap at most
   assign ack_sum  = {1'b0, ptr_ff} + dist_ff[SUM_W-1:0];
   assign ack_wrap = ack_sum - DEPTH_SUM;
   assign ack_addr = (ack_sum >= DEPTH_SUM) ? ack_wrap[IDX_W-1:0] : ack_sum[IDX_W-1:0];

   always_comb begin
      if (cfg_window_size == '0) begin
         size_clamp = CNT_W'(1);
      end else if (cfg_window_size > DEPTH_SIZE) begin
         size_clamp = DEPTH_CNT;
      end else begin
         size_clamp = CNT_W'(cfg_window_size);
      end
   end

   always_comb begin
      start_in       = start_ff;
      size_in        = size_ff;
      ready_in       = ready_ff;
      ptr_in         = ptr_ff;
      clr_cnt_in     = clr_cnt_ff;
      guard_in       = guard_ff;
      op_in          = op_ff;
      seq_in         = seq_ff;
      dist_in        = dist_ff;
      ign_in         = ign_ff;
      notinit_in     = notinit_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp.ready;
      rsp_seq_in     = rsp_seq_ff;
      rsp_ign_in     = rsp_ign_ff;
      rsp_notinit_in = rsp_notinit_ff;

      if (cmd.load) begin
         op_in  = req_operation;
         seq_in = req_seq_num;
      end
      if (cmd.decode) begin
         dist_in    = seq_dist;
         notinit_in = !is_init && !ready_ff;
         ign_in     = !is_init && ready_ff && seq_dist[SEQ_W-1];
      end
      if (cmd.init) begin
         start_in   = cfg_start_sequence;
         size_in    = size_clamp;
         ready_in   = 1'b1;
         ptr_in     = '0;
         clr_cnt_in = DEPTH_CNT;
      end
      if (cmd.slide) begin
         start_in   = start_ff + slide_count;
         clr_cnt_in = clr_count;
      end
      if (cmd.guard_clr) begin
         guard_in = '0;
      end
      if (cmd.clear_step) begin
         ptr_in     = ptr_step;
         clr_cnt_in = clr_cnt_ff - CNT_W'(1);
      end
      if (cmd.pop) begin
         ptr_in   = ptr_step;
         start_in = start_ff + SEQ_W'(1);
         guard_in = guard_ff + CNT_W'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_seq_in     = ready_ff ? start_ff : cfg_start_sequence;
         rsp_ign_in     = ign_ff;
         rsp_notinit_in = notinit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         size_ff      <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         size_ff      <= size_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      clr_cnt_ff     <= clr_cnt_in;
      guard_ff       <= guard_in;
      op_ff          <= op_in;
      seq_ff         <= seq_in;
      dist_ff        <= dist_in;
      ign_ff         <= ign_in;
      notinit_ff     <= notinit_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_ign_ff     <= rsp_ign_in;
      rsp_notinit_ff <= rsp_notinit_in;
   end

   // acked bitmap as a ring, entry at distance k sits at ptr + k
   assign ram_we    = cmd.clear_step | cmd.pop | cmd.set_ack;
   assign ram_waddr = cmd.set_ack ? ack_addr : ptr_ff;

   bat_ram #(
      .WIDTH (1),
      .DEPTH (WINDOW_MAX)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (cmd.set_ack),
      .re    (cmd.walk_read),
      .raddr (ptr_ff),
      .rdata (ram_rdata)
   );

   assign status.op         = op_ff;
   assign status.ready      = ready_ff;
   assign status.old        = seq_dist[SEQ_W-1];
   assign status.beyond     = beyond;
   assign status.clr_last   = (clr_cnt_ff == CNT_W'(1));
   assign status.head_acked = ram_rdata;
   assign status.guard_ok   = (guard_ff < DEPTH_CNT);
   assign status.out_free   = !rsp_valid_ff || rsp.ready;

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.starting_sequence = rsp_seq_ff;
   assign rsp.ignored_old       = rsp_ign_ff;
   assign rsp.not_initialized   = rsp_notinit_ff;

endmodule

>>> rtl/core/block_ack_tx_window.sv
// channel   | dir | handshake          | beat contents
// ----------+-----+--------------------+-----------------------------------------------
// req_beat  | in  | valid / ready      | operation, seq_num
// rsp_beat  | out | valid / ready      | starting_sequence, ignored_old, not_initialized
// csr_*     | in  | apb, pready tied 1 | start_sequence @0x0, window_size @0x4
//
// one event at a time: accept, decode, execute, then a result beat
// a slide clears the vacated entries (at most the active size), then a slide or ack
// walks the head and pops the acked head entries; a transmit inside the window
// and an old or early event go straight to the result; init clears all WINDOW_MAX entries
// the bitmap ram sets the pace: one entry cleared or one head entry checked per step
// reset is synchronous; the bitmap is not cleared by reset, init sweeps it
// a waiting result beat holds; the next event is taken while it waits
module block_ack_tx_window #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   bat_req_if.sink                         req_beat,
   bat_rsp_if.source                       rsp_beat,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bat_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bat_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bat_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   // configuration values as last written
   logic [bat_pkg::SEQ_W-1:0]  cfg_start_sequence;
   logic [bat_pkg::SIZE_W-1:0] cfg_window_size;

   // command and status between sequencer and datapath
   bat_pkg::cmd_type    dp_cmd;
   bat_pkg::status_type dp_status;

   bat_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .prdata         (csr_prdata),
      .pready         (csr_pready),
      .start_sequence (cfg_start_sequence),
      .window_size    (cfg_window_size)
   );

   // sequencer: decode, slide sweep, head walk, result hand-off
   bat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_beat.valid),
      .req_ready (req_beat.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // window registers, bitmap ring and result register
   bat_dp #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_operation      (req_beat.operation),
      .req_seq_num        (req_beat.seq_num),
      .cfg_start_sequence (cfg_start_sequence),
      .cfg_window_size    (cfg_window_size),
      .rsp                (rsp_beat)
   );

   // only one event in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_beat.valid && req_beat.ready) |=> !req_beat.ready)
      else $error("input taken while an event is in flight");

   // at most one bitmap or window action per cycle
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.load, dp_cmd.init, dp_cmd.slide, dp_cmd.set_ack,
                dp_cmd.clear_step, dp_cmd.walk_read, dp_cmd.pop, dp_cmd.emit}))
      else $error("conflicting datapath commands");

   // a head pop always follows a read of the head
   a_pop_after_read: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.pop |-> $past(dp_cmd.walk_read))
      else $error("head popped without a read");

   // a result is only loaded when the output register is free, and then shows
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |=> rsp_beat.valid)
      else $error("result beat lost");

endmodule
